FILE: sv/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg: constants for the level to colour ramp
// Stop positions and per-segment reciprocals of the seven-stop ramp, worked
// out at elaboration from the level fraction width, and its stop colours.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_W         = 20;
  localparam int NUM_STOPS       = 7;
  localparam int NUM_SEG         = NUM_STOPS - 1;
  localparam int SEG_W           = 3;

  // clamped level holds 0..ONE
  localparam int LVL_W   = LEVEL_FRAC_BITS + 1;
  // segment widths are at least 2^(frac-3), so the reciprocal fits in this
  localparam int RECIP_W = 36 - LEVEL_FRAC_BITS;
  localparam int PROD_W  = LVL_W + RECIP_W;
  localparam int T_W     = 17;
  localparam int ACC_W   = 27;

  localparam logic [31:0] ONE   = 32'd1 << LEVEL_FRAC_BITS;
  localparam logic [63:0] ONE64 = 64'(ONE);
  localparam logic [T_W-1:0] T_MAX = T_W'(65536);
  localparam logic [7:0] ALPHA = 8'hFF;

  localparam logic [LVL_W-1:0] STOP_POS [NUM_STOPS] = '{
    LVL_W'((64'd0   * ONE64 + 64'd50) / 64'd100),
    LVL_W'((64'd18  * ONE64 + 64'd50) / 64'd100),
    LVL_W'((64'd38  * ONE64 + 64'd50) / 64'd100),
    LVL_W'((64'd56  * ONE64 + 64'd50) / 64'd100),
    LVL_W'((64'd72  * ONE64 + 64'd50) / 64'd100),
    LVL_W'((64'd86  * ONE64 + 64'd50) / 64'd100),
    LVL_W'((64'd100 * ONE64 + 64'd50) / 64'd100)
  };

  localparam logic [63:0] SEG_WIDTH [NUM_SEG] = '{
    64'(STOP_POS[1]) - 64'(STOP_POS[0]),
    64'(STOP_POS[2]) - 64'(STOP_POS[1]),
    64'(STOP_POS[3]) - 64'(STOP_POS[2]),
    64'(STOP_POS[4]) - 64'(STOP_POS[3]),
    64'(STOP_POS[5]) - 64'(STOP_POS[4]),
    64'(STOP_POS[6]) - 64'(STOP_POS[5])
  };

  localparam logic [RECIP_W-1:0] RECIP [NUM_SEG] = '{
    RECIP_W'(((64'd1 << 32) + SEG_WIDTH[0] / 64'd2) / SEG_WIDTH[0]),
    RECIP_W'(((64'd1 << 32) + SEG_WIDTH[1] / 64'd2) / SEG_WIDTH[1]),
    RECIP_W'(((64'd1 << 32) + SEG_WIDTH[2] / 64'd2) / SEG_WIDTH[2]),
    RECIP_W'(((64'd1 << 32) + SEG_WIDTH[3] / 64'd2) / SEG_WIDTH[3]),
    RECIP_W'(((64'd1 << 32) + SEG_WIDTH[4] / 64'd2) / SEG_WIDTH[4]),
    RECIP_W'(((64'd1 << 32) + SEG_WIDTH[5] / 64'd2) / SEG_WIDTH[5])
  };

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t STOP_RGB [NUM_STOPS] = '{
    '{8'd4,   8'd6,   8'd16},
    '{8'd18,  8'd30,  8'd92},
    '{8'd24,  8'd86,  8'd160},
    '{8'd34,  8'd160, 8'd148},
    '{8'd176, 8'd196, 8'd64},
    '{8'd244, 8'd158, 8'd48},
    '{8'd255, 8'd246, 8'd214}
  };

endpackage

FILE: sv/level_to_colour_ramp_core.sv
// ----------------------------------------------------------------------------
// level_to_colour_ramp_core: level to waterfall colour
// Clamps a fixed-point level to 0..1 and interpolates a seven-stop colour
// ramp, one pixel per clock unless the output stalls, through a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: level (signed, LEVEL_FRAC_BITS fraction bits) with
//   in_valid / in_stall; a request is taken at a clock edge with in_valid
//   high and in_stall low.
//   output channel: red, green, blue and argb_word (alpha 0xFF on top) with
//   out_valid / out_stall; a result is taken when out_valid is high and
//   out_stall is low.
//   pipeline: five register stages, the first loaded by the edge that takes
//   the request (clamp, segment select, reciprocal multiply, channel
//   multiply, round and saturate).
//   throughput: one request per clock unless a waiting result is stalled; no
//   stage loops, so every stage takes a new item whenever the pipeline advances.
//   reset (rst, synchronous) empties the pipeline; out_valid drops.
//   while the receiver stalls a waiting result, the whole pipeline holds
//   and in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module level_to_colour_ramp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [lcr_pkg::LEVEL_W-1:0] level,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [31:0]                 argb_word,
  output logic                        out_valid,
  input  logic                        out_stall
);

  localparam int LVL_W   = lcr_pkg::LVL_W;
  localparam int SEG_W   = lcr_pkg::SEG_W;
  localparam int PROD_W  = lcr_pkg::PROD_W;
  localparam int RECIP_W = lcr_pkg::RECIP_W;
  localparam int T_W     = lcr_pkg::T_W;
  localparam int ACC_W   = lcr_pkg::ACC_W;

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stage 1: clamp
  logic             v1;
  logic [LVL_W-1:0] lvl1;
  logic [LVL_W-1:0] lvl1_next;

  always_comb begin
    if (level[lcr_pkg::LEVEL_W-1]) begin
      lvl1_next = '0;
    end else if (32'($unsigned(level)) > lcr_pkg::ONE) begin
      lvl1_next = LVL_W'(lcr_pkg::ONE);
    end else begin
      lvl1_next = LVL_W'($unsigned(level));
    end
  end

  // stage 2: segment select and offset into it
  logic             v2;
  logic [SEG_W-1:0] seg2;
  logic [LVL_W-1:0] off2;
  logic [SEG_W-1:0] seg2_next;

  // on a stop the lower segment wins, so only strictly lower stops count
  always_comb begin
    seg2_next = '0;
    for (int k = 1; k < lcr_pkg::NUM_SEG; k++) begin
      if (lcr_pkg::STOP_POS[k] < lvl1) begin
        seg2_next = SEG_W'(k);
      end
    end
  end

  // stage 3: offset times segment reciprocal
  logic              v3;
  logic [SEG_W-1:0]  seg3;
  logic [PROD_W-1:0] prod3;
  logic [RECIP_W-1:0] recip2;

  assign recip2 = lcr_pkg::RECIP[seg2];

  // stage 4: t in Q1.16 and per-channel blend sums
  logic                    v4;
  logic signed [ACC_W-1:0] acc4 [3];
  logic [PROD_W-16-1:0]    tr3;
  logic [T_W-1:0]          t3;
  lcr_pkg::rgb_t           lo3;
  lcr_pkg::rgb_t           hi3;
  logic [7:0]              lo_ch [3];
  logic [7:0]              hi_ch [3];

  assign tr3 = (PROD_W - 16)'((prod3 + PROD_W'(32768)) >> 16);
  assign t3  = (tr3 > (PROD_W - 16)'(lcr_pkg::T_MAX)) ? lcr_pkg::T_MAX : T_W'(tr3);
  assign lo3 = lcr_pkg::STOP_RGB[seg3];
  assign hi3 = lcr_pkg::STOP_RGB[seg3 + SEG_W'(1)];
  assign lo_ch[0] = lo3.r;
  assign lo_ch[1] = lo3.g;
  assign lo_ch[2] = lo3.b;
  assign hi_ch[0] = hi3.r;
  assign hi_ch[1] = hi3.g;
  assign hi_ch[2] = hi3.b;

  // stage 5: round down by 2^16 and saturate
  logic [7:0] ch5_next [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc4[c][ACC_W-1]) begin
        ch5_next[c] = '0;
      end else if (acc4[c][ACC_W-2:16] > (ACC_W - 17)'(255)) begin
        ch5_next[c] = 8'hFF;
      end else begin
        ch5_next[c] = acc4[c][23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lvl1  <= lvl1_next;
      seg2  <= seg2_next;
      off2  <= lvl1 - lcr_pkg::STOP_POS[seg2_next];
      seg3  <= seg2;
      prod3 <= PROD_W'(off2) * PROD_W'(recip2);
      for (int c = 0; c < 3; c++) begin
        acc4[c] <= $signed({3'b000, lo_ch[c], 16'h0000})
                 + ACC_W'(($signed({1'b0, hi_ch[c]}) - $signed({1'b0, lo_ch[c]}))
                          * $signed({1'b0, t3}))
                 + ACC_W'(32768);
      end
      red   <= ch5_next[0];
      green <= ch5_next[1];
      blue  <= ch5_next[2];
    end
  end

  assign argb_word = {lcr_pkg::ALPHA, red, green, blue};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (seg2 < SEG_W'(lcr_pkg::NUM_SEG)))
    else $error("segment index beyond last segment");

  a_offset_in_segment: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (64'(off2) <= lcr_pkg::SEG_WIDTH[seg2]))
    else $error("offset wider than its segment");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(v4) && $stable(v3) && $stable(red)
                                  && $stable(green) && $stable(blue)))
    else $error("pipeline moved while the result was stalled");

endmodule

FILE: dv/tb_level_to_colour_ramp_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_level_to_colour_ramp_core: self-checking bench for the colour ramp core
// Drives levels over the request channel with random gaps and random output
// stalls. A scoreboard predicts each colour from the clamped level and the
// seven-stop ramp, then compares red, green, blue and the packed word.
// ----------------------------------------------------------------------------

typedef logic signed [lcr_pkg::LEVEL_W-1:0] level_t;
typedef longint unsigned u64_t;

typedef struct packed {
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] argb;
} colour_t;

localparam int unsigned RAMP_PCT [7] = '{0, 18, 38, 56, 72, 86, 100};

localparam bit [7:0] RAMP_RGB [7][3] = '{
  '{8'd4,   8'd6,   8'd16},
  '{8'd18,  8'd30,  8'd92},
  '{8'd24,  8'd86,  8'd160},
  '{8'd34,  8'd160, 8'd148},
  '{8'd176, 8'd196, 8'd64},
  '{8'd244, 8'd158, 8'd48},
  '{8'd255, 8'd246, 8'd214}
};

// stop position in level units, rounded to nearest
function automatic longint ramp_stop(int k);
  longint one = longint'(1) << lcr_pkg::LEVEL_FRAC_BITS;
  return (longint'(RAMP_PCT[k]) * one + 50) / 100;
endfunction

class colour_ramp_checker;
  colour_t expected_colours[$];
  int      mismatches = 0;

  function colour_t ramp_colour(level_t lv);
    longint     one, lvl, lo_pos, hi_pos, width, offset, t, acc;
    u64_t       recip;
    int         upper;
    logic [7:0] chan [3];
    colour_t    c;
    one = longint'(1) << lcr_pkg::LEVEL_FRAC_BITS;
    lvl = longint'(lv);
    if (lvl < 0) lvl = 0;
    if (lvl > one) lvl = one;
    // a level sitting on a stop stays in the lower segment
    upper = 1;
    while (upper + 1 < 7 && ramp_stop(upper) < lvl) upper++;
    lo_pos = ramp_stop(upper - 1);
    hi_pos = ramp_stop(upper);
    width  = hi_pos - lo_pos;
    offset = lvl - lo_pos;
    if (offset < 0) offset = 0;
    if (width <= 0) begin
      t = 0;
    end else begin
      recip = ((u64_t'(1) << 32) + u64_t'(width) / 2) / u64_t'(width);
      t = longint'((u64_t'(offset) * recip + 32768) >> 16);
      if (t > 65536) t = 65536;
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = longint'(RAMP_RGB[upper-1][ch]) * 65536
          + (longint'(RAMP_RGB[upper][ch]) - longint'(RAMP_RGB[upper-1][ch])) * t + 32768;
      if (acc < 0) acc = 0;
      acc = acc >>> 16;
      if (acc > 255) acc = 255;
      chan[ch] = acc[7:0];
    end
    c.red   = chan[0];
    c.green = chan[1];
    c.blue  = chan[2];
    c.argb  = {8'hFF, chan[0], chan[1], chan[2]};
    return c;
  endfunction

  function void note_level(level_t lv);
    expected_colours.push_back(ramp_colour(lv));
  endfunction

  function void check_colour(colour_t got);
    colour_t want;
    if (expected_colours.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no request pending: r=%0d g=%0d b=%0d argb=%h",
                 $realtime, got.red, got.green, got.blue, got.argb);
      return;
    end
    want = expected_colours.pop_front();
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.argb !== want.argb) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: colour mismatch: exp r=%0d g=%0d b=%0d argb=%h, got r=%0d g=%0d b=%0d argb=%h",
                 $realtime, want.red, want.green, want.blue, want.argb,
                 got.red, got.green, got.blue, got.argb);
    end
  endfunction
endclass

module tb_level_to_colour_ramp_core;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 517;
  localparam int TAIL_CYCLES     = 20;
  localparam int W               = lcr_pkg::LEVEL_W;

  logic        clk;
  logic        rst       = 1'b1;
  level_t      level     = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  red, green, blue;
  logic [31:0] argb_word;
  logic        out_valid;
  logic        out_stall = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;

  colour_ramp_checker colour_sb = new;

  level_to_colour_ramp_core DUT (
    .clk       (clk),
    .rst       (rst),
    .level     (level),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .argb_word (argb_word),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check what is taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      colour_sb.check_colour(colour_t'{red, green, blue, argb_word});
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_level(input level_t v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      level    <= level_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    level    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    colour_sb.note_level(v);
  endtask

  // hold off new requests until every pending colour has come back
  task automatic drain_colours();
    in_valid <= 1'b0;
    while (colour_sb.expected_colours.size() != 0) @(posedge clk);
  endtask

  function automatic level_t random_level();
    int k;
    case ($urandom_range(9))
      0, 1: return level_t'($urandom);
      2: begin
        k = $urandom_range(6);
        return level_t'(ramp_stop(k) + int'($urandom_range(6)) - 3);
      end
      default: return level_t'($urandom_range(32'(ramp_stop(6))));
    endcase
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** level_to_colour_ramp_core: FAILED **");
    $finish;
  end

  initial begin
    longint one;
    one = ramp_stop(6);
    tx_idle_pct = 37;
    rx_idle_pct = 76;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // extremes, clamp edges and zero
    send_level(level_t'(1 << (W - 1)));
    send_level(level_t'((1 << (W - 1)) - 1));
    send_level(level_t'(-1));
    send_level(level_t'(0));
    send_level(level_t'(1));
    send_level(level_t'(one - 1));
    send_level(level_t'(one));
    send_level(level_t'(one + 1));
    // on each inner stop and just past it
    for (int k = 1; k < 6; k++) begin
      send_level(level_t'(ramp_stop(k)));
      send_level(level_t'(ramp_stop(k) + 1));
    end
    for (int k = 0; k < 6; k++)
      send_level(level_t'((ramp_stop(k) + ramp_stop(k + 1)) / 2));
    drain_colours();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 37; rx_idle_pct = 76; end
        1: begin tx_idle_pct = 76; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (ITEMS_PER_PHASE) send_level(random_level());
      drain_colours();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (colour_sb.mismatches == 0 && colour_sb.expected_colours.size() == 0) begin
      $display("** level_to_colour_ramp_core: PASSED **");
    end else begin
      $display("** level_to_colour_ramp_core: FAILED **");
    end
    $finish;
  end

endmodule
